[rtl/core/serial_valve_command_decoder_core_macros.svh]
// Assertion macros shared by the serial valve command decoder checker
`ifndef SERIAL_VALVE_COMMAND_DECODER_CORE_MACROS_SVH
`define SERIAL_VALVE_COMMAND_DECODER_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, quiet while rst_n is low
`define SVCD_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, quiet while rst_n is low
`define SVCD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/svcd_pkg.sv]
// Package: types and constants of the serial valve command decoder
package svcd_pkg;

    localparam int NUM_OUTPUTS_DEF = 12;
    localparam int LINE_MAX_DEF    = 32;

    localparam int BYTE_W  = 8;
    localparam int COUNT_W = 6;
    localparam int PORT_W  = 5;
    localparam int DIGIT_W = 4;
    localparam int BITS_W  = 12;
    localparam int LEVEL_W = 16;
    localparam int OUT_W   = 24;

    localparam logic [PORT_W-1:0] PORT_SAT = 5'd31;

    localparam logic [BYTE_W-1:0] CH_NUL   = 8'h00;
    localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_P     = 8'h50;
    localparam logic [BYTE_W-1:0] CH_S     = 8'h53;
    localparam logic [BYTE_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [BYTE_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;
    localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
    localparam logic [BYTE_W-1:0] CH_VT    = 8'h0B;
    localparam logic [BYTE_W-1:0] CH_FF    = 8'h0C;

    typedef enum logic [1:0] {
        PH_WAIT,
        PH_LEAD,
        PH_DIGITS,
        PH_DONE
    } phase_t;

    typedef struct packed {
        phase_t               phase;
        logic                 neg;
        logic                 digit;
        logic [DIGIT_W-1:0]   dval;
    } parse_t;

endpackage

[rtl/core/serial_valve_command_decoder_core.sv]
// Top level: serial valve command decoder, one received byte per transaction
//
// Slave channel (s_tvalid/s_tready/s_tdata) takes one ASCII byte per
// transaction. Lines such as "P5S1" end with LF or CR; each terminator
// yields one master transaction (m_tvalid/m_tready/m_tdata) carrying
// command_applied, port_number, port_level and the 12 visible valve bits.
// Other bytes only update the line parsers and give no transaction.
// A byte passes an input register, then the parsers and the valve update
// act on it and the result lands in the output register.
// Throughput is one byte per cycle; the input register is the only place a
// byte waits, so a terminator blocks only while a previous result is still
// held by a stalled receiver. Non-terminator bytes keep flowing then.
// Lines longer than LINE_MAX-1 bytes are dropped and parsing restarts.
// Reset clears the valve levels, the line state and both valid flags.
module serial_valve_command_decoder_core
    import svcd_pkg::*;
#(
    parameter int NUM_OUTPUTS = NUM_OUTPUTS_DEF,
    parameter int LINE_MAX    = LINE_MAX_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [BYTE_W-1:0]   s_tdata,   // [7:0] rx_byte
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [OUT_W-1:0]    m_tdata    // [0] command_applied, [4:1] port_number,
                                           // [5] port_level, [17:6] output_bits, [23:18] zero
);

    localparam logic [PORT_W-1:0]  NUM_OUT_V  = PORT_W'(NUM_OUTPUTS);
    localparam logic [COUNT_W-1:0] COUNT_LAST = COUNT_W'(LINE_MAX - 1);

    logic                   in_valid_reg, in_valid_next;
    logic [BYTE_W-1:0]      in_byte_reg, in_byte_next;
    logic                   out_valid_reg, out_valid_next;
    logic [OUT_W-1:0]       out_data_reg, out_data_next;

    logic [NUM_OUTPUTS-1:0] levels_reg, levels_next;
    logic [COUNT_W-1:0]     count_reg, count_next;
    logic                   nul_reg, nul_next;
    phase_t                 port_phase_reg, port_phase_next;
    logic [PORT_W-1:0]      port_val_reg, port_val_next;
    logic                   port_neg_reg, port_neg_next;
    phase_t                 lvl_phase_reg, lvl_phase_next;
    logic                   lvl_nz_reg, lvl_nz_next;

    parse_t                 port_step;
    parse_t                 lvl_step;

    logic                   is_term;
    logic                   advance;
    logic                   have_both;
    logic                   in_range;
    logic                   apply;
    logic [NUM_OUTPUTS-1:0] bit_mask;
    logic [8:0]             port_acc;
    logic [LEVEL_W-1:0]     levels_wide;

    svcd_field_parser u_port_parser
    (
        .phase   (port_phase_reg),
        .char_in (in_byte_reg),
        .marker  (CH_P),
        .step    (port_step)
    );

    svcd_field_parser u_level_parser
    (
        .phase   (lvl_phase_reg),
        .char_in (in_byte_reg),
        .marker  (CH_S),
        .step    (lvl_step)
    );

    assign is_term  = (in_byte_reg == CH_LF) || (in_byte_reg == CH_CR);
    assign advance  = in_valid_reg && (!is_term || !out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    assign have_both = (port_phase_reg != PH_WAIT) && (lvl_phase_reg != PH_WAIT);
    assign in_range  = (port_val_reg < NUM_OUT_V) &&
                       !(port_neg_reg && (port_val_reg != '0));
    assign apply     = have_both && in_range;
    assign bit_mask  = NUM_OUTPUTS'(1) << port_val_reg[DIGIT_W-1:0];
    // val*10 + digit as two shifted adds
    assign port_acc  = {1'b0, port_val_reg, 3'b000} + {3'b000, port_val_reg, 1'b0}
                     + {5'b00000, port_step.dval};

    always_comb
    begin
        in_valid_next = in_valid_reg;
        in_byte_next  = in_byte_reg;
        if (s_tready)
        begin
            in_valid_next = s_tvalid;
            if (s_tvalid)
            begin
                in_byte_next = s_tdata;
            end
        end
    end

    always_comb
    begin
        levels_next     = levels_reg;
        count_next      = count_reg;
        nul_next        = nul_reg;
        port_phase_next = port_phase_reg;
        port_val_next   = port_val_reg;
        port_neg_next   = port_neg_reg;
        lvl_phase_next  = lvl_phase_reg;
        lvl_nz_next     = lvl_nz_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_data_next   = out_data_reg;
        levels_wide     = '0;

        if (advance)
        begin
            if (is_term || (count_reg >= COUNT_LAST))
            begin
                // start a fresh line
                count_next      = '0;
                nul_next        = 1'b0;
                port_phase_next = PH_WAIT;
                port_val_next   = '0;
                port_neg_next   = 1'b0;
                lvl_phase_next  = PH_WAIT;
                lvl_nz_next     = 1'b0;
            end
            else
            begin
                count_next = count_reg + COUNT_W'(1);
                if (!nul_reg)
                begin
                    if (in_byte_reg == CH_NUL)
                    begin
                        nul_next = 1'b1;
                    end
                    else
                    begin
                        port_phase_next = port_step.phase;
                        lvl_phase_next  = lvl_step.phase;
                        if (port_step.neg)
                        begin
                            port_neg_next = 1'b1;
                        end
                        if (port_step.digit)
                        begin
                            port_val_next = (port_acc > 9'(PORT_SAT)) ? PORT_SAT
                                                                      : port_acc[PORT_W-1:0];
                        end
                        if (lvl_step.digit && (lvl_step.dval != '0))
                        begin
                            lvl_nz_next = 1'b1;
                        end
                    end
                end
            end

            if (is_term)
            begin
                if (apply)
                begin
                    levels_next = lvl_nz_reg ? (levels_reg | bit_mask)
                                             : (levels_reg & ~bit_mask);
                end
                levels_wide    = LEVEL_W'(levels_next);
                out_valid_next = 1'b1;
                out_data_next  = {6'b000000,
                                  levels_wide[BITS_W-1:0],
                                  apply && lvl_nz_reg,
                                  apply ? port_val_reg[DIGIT_W-1:0] : 4'd0,
                                  apply};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            levels_reg     <= '0;
            count_reg      <= '0;
            nul_reg        <= 1'b0;
            port_phase_reg <= PH_WAIT;
            port_val_reg   <= '0;
            port_neg_reg   <= 1'b0;
            lvl_phase_reg  <= PH_WAIT;
            lvl_nz_reg     <= 1'b0;
        end
        else
        begin
            in_valid_reg   <= in_valid_next;
            out_valid_reg  <= out_valid_next;
            levels_reg     <= levels_next;
            count_reg      <= count_next;
            nul_reg        <= nul_next;
            port_phase_reg <= port_phase_next;
            port_val_reg   <= port_val_next;
            port_neg_reg   <= port_neg_next;
            lvl_phase_reg  <= lvl_phase_next;
            lvl_nz_reg     <= lvl_nz_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_byte_reg  <= in_byte_next;
        out_data_reg <= out_data_next;
    end

endmodule

[rtl/core/svcd_field_parser.sv]
// Field parser: advances one marker/sign/digit scanner by one character
module svcd_field_parser
    import svcd_pkg::*;
(
    input  phase_t              phase,
    input  logic [BYTE_W-1:0]   char_in,
    input  logic [BYTE_W-1:0]   marker,
    output parse_t              step
);

    logic is_blank;
    logic is_sign;
    logic is_digit;

    assign is_blank = char_in inside {CH_SPACE, CH_TAB, CH_VT, CH_FF};
    assign is_sign  = char_in inside {CH_PLUS, CH_MINUS};
    assign is_digit = char_in inside {[CH_ZERO:CH_NINE]};

    always_comb
    begin
        step.phase = PH_DONE;
        step.neg   = 1'b0;
        step.digit = 1'b0;
        step.dval  = char_in[DIGIT_W-1:0];
        case (phase)
            PH_WAIT:
            begin
                step.phase = (char_in == marker) ? PH_LEAD : PH_WAIT;
            end
            PH_LEAD:
            begin
                if (is_blank)
                begin
                    step.phase = PH_LEAD;
                end
                else if (is_sign)
                begin
                    step.phase = PH_DIGITS;
                    step.neg   = (char_in == CH_MINUS);
                end
                else if (is_digit)
                begin
                    step.phase = PH_DIGITS;
                    step.digit = 1'b1;
                end
            end
            PH_DIGITS:
            begin
                if (is_digit)
                begin
                    step.phase = PH_DIGITS;
                    step.digit = 1'b1;
                end
            end
            default:
            begin
                step.phase = PH_DONE;
            end
        endcase
    end

endmodule

[rtl/core/svcd_checker.sv]
// Checker: port-level assertions for the serial valve command decoder
`include "serial_valve_command_decoder_core_macros.svh"

module svcd_checker
    import svcd_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic [BYTE_W-1:0]    s_tdata,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [OUT_W-1:0]     m_tdata
);

    // hold an offered byte until it is taken
    `SVCD_ASSERT_NEXT(a_in_hold, s_tvalid && !s_tready, s_tvalid && $stable(s_tdata), "offered byte changed before acceptance")

    // hold a stalled result
    `SVCD_ASSERT_NEXT(a_stall_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")

    // a rejected line reports neither port nor level
    `SVCD_ASSERT_IMPL(a_reject_zero, m_tvalid && !m_tdata[0], (m_tdata[4:1] == 4'd0) && !m_tdata[5], "rejected line carries port or level")

    // an applied command shows its level on the visible valve bit
    `SVCD_ASSERT_IMPL(a_applied_bit, m_tvalid && m_tdata[0] && (m_tdata[4:1] < 4'd12), ((m_tdata[17:6] >> m_tdata[4:1]) & 12'd1) == {11'd0, m_tdata[5]}, "valve bit disagrees with applied level")

    // padding stays zero
    `SVCD_ASSERT_IMPL(a_pad_zero, m_tvalid, m_tdata[23:18] == 6'd0, "padding bits set")

endmodule

bind serial_valve_command_decoder_core svcd_checker u_svcd_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
